// ===== design/vetap_pkg.sv =====
// Shared types, constants and register indexes of the voxel edge taper.
package vetap_pkg;

  localparam int SAMPLE_W   = 32;
  localparam int COORD_W    = 10;
  localparam int EXT_W      = 11;
  localparam int GRID_W     = 33;
  localparam int TAPER_W    = 26;
  localparam int WIDTH_W    = 10;
  localparam int END_W      = 16;
  localparam int NUM_W      = END_W + WIDTH_W;
  localparam int NUM_AXES   = 3;
  localparam int NUM_EDGES  = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 33;

  localparam logic [GRID_W-1:0] EXT_RESET = 33'd4196353;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_GRID_EXTENTS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TAPER_FIRST  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TAPER_LAST   = 3'd6;

  localparam int MAX_EXTENT_DEF  = 1024;
  localparam int SAMPLE_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF   = 15;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic [COORD_W-1:0]         coord_1;
    logic [COORD_W-1:0]         coord_2;
    logic [COORD_W-1:0]         coord_3;
  } in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] tapered_sample;
    logic                       width_error;
  } out_t;

  // One edge of a classified request, in the order the tapers are applied.
  typedef struct packed {
    logic               act;
    logic [END_W-1:0]   end_v;
    logic [NUM_W-1:0]   num;
    logic [WIDTH_W-1:0] w;
  } edge_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       err;
    edge_t [NUM_EDGES-1:0]      edges;
  } job_t;

endpackage

// ===== design/vetap_front.sv =====
// Front end: configuration registers and classification of each request.
module vetap_front import vetap_pkg::*; #(
  parameter int MAX_EXTENT  = MAX_EXTENT_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  in_t                   req_i,
  output job_t                  job_o
);

  localparam int SH = SAMPLE_W - SAMPLE_BITS;
  localparam logic [END_W:0] ONE = (END_W+1)'(1) << FRAC_BITS;
  localparam logic [EXT_W-1:0] EXT_MAX = EXT_W'(MAX_EXTENT);

  logic [GRID_W-1:0]  ext_q;
  logic [TAPER_W-1:0] taper_q [NUM_EDGES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ext_q <= EXT_RESET;
      for (int i = 0; i < NUM_EDGES; i++) taper_q[i] <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_GRID_EXTENTS) begin
        ext_q <= cfg_data_i[GRID_W-1:0];
      end else if (cfg_idx_i >= REG_TAPER_FIRST && cfg_idx_i <= REG_TAPER_LAST) begin
        taper_q[3'(cfg_idx_i - REG_TAPER_FIRST)] <= cfg_data_i[TAPER_W-1:0];
      end
    end
  end

  logic [EXT_W-1:0]   ext [NUM_AXES];
  logic [COORD_W-1:0] crd [NUM_AXES];
  logic               err;

  always_comb begin
    logic [EXT_W-1:0]   e;
    logic [WIDTH_W-1:0] w;
    logic [TAPER_W-1:0] r;
    logic [EXT_W-1:0]   dh;
    logic [COORD_W-1:0] d;
    logic               inside_grid;
    logic [END_W-1:0]   ev;
    logic [END_W-1:0]   diff;
    crd[0] = req_i.coord_1;
    crd[1] = req_i.coord_2;
    crd[2] = req_i.coord_3;
    err = 1'b0;
    for (int a = 0; a < NUM_AXES; a++) begin
      e = ext_q[EXT_W*a +: EXT_W];
      ext[a] = (e > EXT_MAX) ? EXT_MAX : e;
      for (int s = 0; s < 2; s++) begin
        w = taper_q[2*a+s][TAPER_W-1:END_W];
        if (w != '0 && {1'b0, w} > (ext[a] >> 1)) err = 1'b1;
      end
    end
    job_o.sample = $signed(req_i.sample <<< SH) >>> SH;
    job_o.err    = err;
    for (int k = 0; k < NUM_EDGES; k++) begin
      r  = taper_q[2*(k % NUM_AXES) + k / NUM_AXES];
      w  = r[TAPER_W-1:END_W];
      dh = ext[k % NUM_AXES] - EXT_W'(1) - {1'b0, crd[k % NUM_AXES]};
      if (k < NUM_AXES) begin
        d = crd[k % NUM_AXES];
        inside_grid = 1'b1;
      end else begin
        d = dh[COORD_W-1:0];
        inside_grid = {1'b0, crd[k % NUM_AXES]} < ext[k % NUM_AXES];
      end
      // End values above one act as zero.
      ev   = ({1'b0, r[END_W-1:0]} > ONE) ? '0 : r[END_W-1:0];
      diff = END_W'(ONE - {1'b0, ev});
      job_o.edges[k].act   = !err && (w != '0) && inside_grid && (d < w);
      job_o.edges[k].end_v = ev;
      job_o.edges[k].num   = NUM_W'(diff * d);
      job_o.edges[k].w     = w;
    end
  end

endmodule

// ===== design/vetap_fifo.sv =====
// Two-entry queue between the front end and the back end.
module vetap_fifo import vetap_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t data_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output job_t data_o
);

  job_t       mem_q [2];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

  always_comb begin
    wr_d  = push_i ? !wr_q : wr_q;
    rd_d  = pop_i ? !rd_q : rd_q;
    cnt_d = cnt_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  assign full_o  = cnt_q[1];
  assign valid_o = cnt_q != '0;
  assign data_o  = mem_q[rd_q];

endmodule

// ===== design/vetap_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
module vetap_div import vetap_pkg::*; #(
  parameter int QB = FRAC_BITS_DEF + 1
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [NUM_W-1:0]   num_i,
  input  logic [WIDTH_W-1:0] w_i,
  output logic [QB-1:0]      q_o
);

  // The quotient is known to stay below 2**QB, so the bits above QB start
  // as a partial remainder smaller than the divisor.
  logic [WIDTH_W-1:0] rem_q [QB];
  logic [QB-1:0]      quo_q [QB];
  logic [QB-1:0]      low_q [QB];
  logic [WIDTH_W-1:0] w_q   [QB];

  for (genvar i = 0; i < QB; i++) begin : g_stage
    logic [WIDTH_W-1:0] rem_in, w_in;
    logic [QB-1:0]      quo_in, low_in, quo_out;
    logic [WIDTH_W:0]   trial;
    logic [WIDTH_W-1:0] rem_out;

    if (i == 0) begin : g_first
      assign rem_in = num_i[QB +: WIDTH_W];
      assign low_in = num_i[QB-1:0];
      assign w_in   = w_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[i-1];
      assign low_in = low_q[i-1];
      assign w_in   = w_q[i-1];
      assign quo_in = quo_q[i-1];
    end

    always_comb begin
      trial   = {rem_in, low_in[QB-1-i]};
      quo_out = quo_in;
      rem_out = trial[WIDTH_W-1:0];
      if (trial >= {1'b0, w_in}) begin
        rem_out = WIDTH_W'(trial - {1'b0, w_in});
        quo_out[QB-1-i] = 1'b1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i] <= rem_out;
        quo_q[i] <= quo_out;
        low_q[i] <= low_in;
        w_q[i]   <= w_in;
      end
    end
  end

  assign q_o = quo_q[QB-1];

endmodule

// ===== design/vetap_back.sv =====
// Back end: divider lanes, then the chain of six taper multiplies.
module vetap_back import vetap_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic job_valid_i,
  input  job_t job_i,
  output logic pop_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_rsp_o
);

  localparam int QB = FRAC_BITS + 1;
  localparam logic [QB-1:0] ONE = QB'(1) << FRAC_BITS;
  localparam int PW = SAMPLE_W + 17;

  typedef logic [QB-1:0] mult_t [NUM_EDGES];

  logic en;

  // Side line carrying what the dividers do not.
  logic                       sv_q  [QB];
  logic signed [SAMPLE_W-1:0] ss_q  [QB];
  logic                       se_q  [QB];
  logic [NUM_EDGES-1:0]       sa_q  [QB];
  logic [END_W-1:0]           sn_q  [QB][NUM_EDGES];
  logic [QB-1:0]              quo   [NUM_EDGES];

  for (genvar k = 0; k < NUM_EDGES; k++) begin : g_lane
    vetap_div #(.QB(QB)) u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (job_i.edges[k].num),
      .w_i   (job_i.edges[k].w),
      .q_o   (quo[k])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < QB; i++) sv_q[i] <= 1'b0;
    end else if (en) begin
      sv_q[0] <= pop_o;
      for (int i = 1; i < QB; i++) sv_q[i] <= sv_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ss_q[0] <= job_i.sample;
      se_q[0] <= job_i.err;
      for (int k = 0; k < NUM_EDGES; k++) begin
        sa_q[0][k] <= job_i.edges[k].act;
        sn_q[0][k] <= job_i.edges[k].end_v;
      end
      for (int i = 1; i < QB; i++) begin
        ss_q[i] <= ss_q[i-1];
        se_q[i] <= se_q[i-1];
        sa_q[i] <= sa_q[i-1];
        sn_q[i] <= sn_q[i-1];
      end
    end
  end

  function automatic logic signed [SAMPLE_W-1:0] scale(
    input logic signed [SAMPLE_W-1:0] s,
    input logic [QB-1:0]              m
  );
    logic [16:0]          mz;
    logic signed [PW-1:0] p;
    logic signed [PW-1:0] bias;
    mz   = 17'(m);
    p    = PW'(s) * PW'($signed(mz));
    bias = p[PW-1] ? PW'((64'd1 << FRAC_BITS) - 64'd1) : '0;
    p    = (p + bias) >>> FRAC_BITS;
    return p[SAMPLE_W-1:0];
  endfunction

  mult_t m_all;
  always_comb begin
    for (int k = 0; k < NUM_EDGES; k++) begin
      m_all[k] = sa_q[QB-1][k] ? QB'(sn_q[QB-1][k][QB-1:0] + quo[k]) : ONE;
    end
  end

  logic                       cv_q [NUM_EDGES];
  logic signed [SAMPLE_W-1:0] cs_q [NUM_EDGES];
  logic                       ce_q [NUM_EDGES];
  mult_t                      cm_q [NUM_EDGES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < NUM_EDGES; j++) cv_q[j] <= 1'b0;
    end else if (en) begin
      cv_q[0] <= sv_q[QB-1];
      for (int j = 1; j < NUM_EDGES; j++) cv_q[j] <= cv_q[j-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cs_q[0] <= scale(ss_q[QB-1], m_all[0]);
      ce_q[0] <= se_q[QB-1];
      cm_q[0] <= m_all;
      for (int j = 1; j < NUM_EDGES; j++) begin
        cs_q[j] <= scale(cs_q[j-1], cm_q[j-1][j]);
        ce_q[j] <= ce_q[j-1];
        cm_q[j] <= cm_q[j-1];
      end
    end
  end

  assign en          = !(cv_q[NUM_EDGES-1] && !out_ready_i);
  assign pop_o       = en && job_valid_i;
  assign out_valid_o = cv_q[NUM_EDGES-1];
  assign out_rsp_o.tapered_sample = cs_q[NUM_EDGES-1];
  assign out_rsp_o.width_error    = ce_q[NUM_EDGES-1];

endmodule

// ===== design/voxel_edge_linear_taper_core.sv =====
// Top level of the voxel edge taper: front end, request queue and back end.
//
// Each request carries one voxel sample and its three grid coordinates and
// produces one response. Up to six linear edge tapers (low then high edge of
// axis 1, 2, 3) scale the sample in Q1.15 with truncation toward zero; a
// taper width of zero disables an edge, and any enabled width above half its
// axis extent raises width_error and passes the sample unchanged. The block
// accepts one request per clock cycle and returns one response per cycle
// while out_ready_i stays high. An accepted request passes the queue, then
// a divider that resolves the per-edge taper fraction one quotient bit per
// stage, and then a chain of six registered multiplies that applies the six
// tapers. A two-entry queue between the classifier and the arithmetic
// pipeline lets requests keep arriving, until it is full, while a finished
// response waits on out_ready_i. Configuration is written through a simple
// write port (no read-back) and must only change while the block is idle.
module voxel_edge_linear_taper_core import vetap_pkg::*; #(
  parameter int MAX_EXTENT  = MAX_EXTENT_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_t                   in_req_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_t                  out_rsp_o
);

  job_t job_front, job_queue;
  logic full, queue_valid, pop;

  // The front end classifies every edge in the cycle the request arrives.
  vetap_front #(
    .MAX_EXTENT  (MAX_EXTENT),
    .SAMPLE_BITS (SAMPLE_BITS),
    .FRAC_BITS   (FRAC_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req_i      (in_req_i),
    .job_o      (job_front)
  );

  assign in_ready_o = !full;

  vetap_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_valid_i && in_ready_o),
    .data_i  (job_front),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (queue_valid),
    .data_o  (job_queue)
  );

  // The back end stalls as a whole only when its output register is held.
  vetap_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (queue_valid),
    .job_i       (job_queue),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

endmodule
